// ===== hdl/key_matrix_to_ascii_encoder_macros.svh =====
// Assertion macros used by the key matrix encoder sequencer (kmae_seq).
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef KEY_MATRIX_TO_ASCII_ENCODER_MACROS_SVH
`define KEY_MATRIX_TO_ASCII_ENCODER_MACROS_SVH

// Same-cycle implication, checked outside reset
`define KMAE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset
`define KMAE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/kmae_pkg.sv =====
`default_nettype none

package kmae_pkg;

  localparam int MATRIX_ROWS = 7;
  localparam int KEY_BITS    = MATRIX_ROWS * 8;

  // Key positions and sequencing marks
  localparam logic [5:0] KEY_SECOND  = 6'd5;
  localparam logic [5:0] KEY_ALPHA   = 6'd15;
  localparam logic [5:0] KEY_ROW0_END = 6'd7;
  localparam logic [5:0] KEY_END     = 6'd56;

  // Byte constants
  localparam logic [6:0] CHR_ESC     = 7'h1B;
  localparam logic [6:0] CHR_BRACKET = 7'h5B;
  localparam logic [6:0] CASE_OFFSET = 7'd32;

  // Encoding of one key: byte count, escape-sequence flag, final character
  typedef struct packed {
    logic [1:0] cnt;
    logic       arrow;
    logic [6:0] chr;
  } kmae_code_t;

  // Byte stream from the key sequencer to the output stage
  typedef struct packed {
    logic       byte_v;
    logic [6:0] byte_val;
    logic       end_v;
  } kmae_stream_t;

  function automatic logic [6:0] fixed_chr(input logic [5:0] key);
    logic [6:0] c;
    case (key)
      6'd7:    c = 7'h7F;
      6'd40:   c = 7'h0D;
      6'd46:   c = 7'h1B;
      6'd9:    c = 7'h20;
      6'd6:    c = 7'h09;
      default: c = 7'h00;
    endcase
    return c;
  endfunction

  function automatic logic [6:0] arrow_chr(input logic [5:0] key);
    logic [6:0] c;
    case (key)
      6'd51:   c = 7'h41;
      6'd48:   c = 7'h42;
      6'd50:   c = 7'h43;
      6'd49:   c = 7'h44;
      default: c = 7'h00;
    endcase
    return c;
  endfunction

  function automatic logic [6:0] alpha_chr(input logic [5:0] key);
    logic [6:0] c;
    case (key)
      6'd14:   c = 7'h61;
      6'd22:   c = 7'h62;
      6'd30:   c = 7'h63;
      6'd13:   c = 7'h64;
      6'd21:   c = 7'h65;
      6'd29:   c = 7'h66;
      6'd37:   c = 7'h67;
      6'd45:   c = 7'h68;
      6'd12:   c = 7'h69;
      6'd20:   c = 7'h6A;
      6'd28:   c = 7'h6B;
      6'd36:   c = 7'h6C;
      6'd44:   c = 7'h6D;
      6'd11:   c = 7'h6E;
      6'd19:   c = 7'h6F;
      6'd27:   c = 7'h70;
      6'd35:   c = 7'h71;
      6'd43:   c = 7'h72;
      6'd10:   c = 7'h73;
      6'd18:   c = 7'h74;
      6'd26:   c = 7'h75;
      6'd34:   c = 7'h76;
      6'd42:   c = 7'h77;
      6'd17:   c = 7'h79;
      6'd25:   c = 7'h7A;
      default: c = 7'h00;
    endcase
    return c;
  endfunction

  function automatic logic [6:0] plain_chr(input logic [5:0] key);
    logic [6:0] c;
    case (key)
      6'd16:   c = 7'h30;
      6'd17:   c = 7'h31;
      6'd25:   c = 7'h32;
      6'd33:   c = 7'h33;
      6'd18:   c = 7'h34;
      6'd26:   c = 7'h35;
      6'd34:   c = 7'h36;
      6'd19:   c = 7'h37;
      6'd27:   c = 7'h38;
      6'd35:   c = 7'h39;
      6'd20:   c = 7'h2C;
      6'd28:   c = 7'h28;
      6'd36:   c = 7'h29;
      6'd44:   c = 7'h2F;
      6'd43:   c = 7'h2A;
      6'd42:   c = 7'h2D;
      6'd41:   c = 7'h2B;
      6'd24:   c = 7'h2E;
      6'd32:   c = 7'h2D;
      6'd12:   c = 7'h3D;
      6'd11:   c = 7'h27;
      6'd10:   c = 7'h5C;
      6'd0:    c = 7'h03;
      6'd1:    c = 7'h1A;
      6'd2:    c = 7'h05;
      6'd3:    c = 7'h01;
      default: c = 7'h00;
    endcase
    return c;
  endfunction

  function automatic logic [6:0] shift_chr(input logic [5:0] key);
    logic [6:0] c;
    case (key)
      6'd16:   c = 7'h29;
      6'd17:   c = 7'h21;
      6'd25:   c = 7'h40;
      6'd33:   c = 7'h23;
      6'd18:   c = 7'h24;
      6'd26:   c = 7'h25;
      6'd34:   c = 7'h5E;
      6'd19:   c = 7'h26;
      6'd27:   c = 7'h2A;
      6'd35:   c = 7'h28;
      6'd20:   c = 7'h3C;
      6'd28:   c = 7'h5B;
      6'd36:   c = 7'h5D;
      6'd44:   c = 7'h3F;
      6'd43:   c = 7'h2A;
      6'd42:   c = 7'h2D;
      6'd41:   c = 7'h2B;
      6'd24:   c = 7'h3E;
      6'd32:   c = 7'h5F;
      6'd12:   c = 7'h3A;
      6'd11:   c = 7'h22;
      6'd10:   c = 7'h3B;
      6'd0:    c = 7'h03;
      6'd1:    c = 7'h1A;
      6'd2:    c = 7'h05;
      6'd3:    c = 7'h01;
      default: c = 7'h00;
    endcase
    return c;
  endfunction

  // Full encoding of one key under the current 2nd and alpha levels
  function automatic kmae_code_t key_code(input logic [5:0] key, input logic second,
                                          input logic alpha_on);
    kmae_code_t r;
    logic [6:0] f;
    logic [6:0] a;
    logic [6:0] l;
    logic [6:0] p;
    f = fixed_chr(key);
    a = arrow_chr(key);
    l = alpha_chr(key);
    p = second ? shift_chr(key) : plain_chr(key);
    r.arrow = 1'b0;
    if (f != 7'h00) begin
      r.cnt = 2'd1;
      r.chr = f;
    end else if (a != 7'h00) begin
      r.cnt   = 2'd3;
      r.arrow = 1'b1;
      r.chr   = a;
    end else if (alpha_on) begin
      r.cnt = (l != 7'h00) ? 2'd1 : 2'd0;
      r.chr = second ? (l - CASE_OFFSET) : l;
    end else begin
      r.cnt = (p != 7'h00) ? 2'd1 : 2'd0;
      r.chr = p;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/kmae_seq.sv =====
`default_nettype none

module kmae_seq (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  scan_valid,
  output logic                       scan_stall,
  input  wire logic [55:0]           scan_bits,
  output kmae_pkg::kmae_stream_t     strm,
  input  wire logic                  strm_rdy
);
  import kmae_pkg::*;

  `include "key_matrix_to_ascii_encoder_macros.svh"

  logic                busy_r;
  logic [5:0]          key_r;
  logic [1:0]          sub_r;
  logic [KEY_BITS-1:0] press_r;
  logic [KEY_BITS-1:0] prev_r;
  logic                rel_alpha_r;
  logic                second_r;
  logic                adown_r;
  logic                lock_r;
  logic                chord_r;
  logic                held_r;

  kmae_code_t code;
  logic       scan_phase;
  logic       is_mod;
  logic       emit;
  logic       last_sub;
  logic       adv;
  logic       take_end;
  logic       chord_nxt;
  logic       lock_nxt;
  logic [6:0] byte_val;

  // Encode the key at the head of the shift register
  assign code       = key_code(key_r, second_r, lock_r | adown_r);
  assign scan_phase = busy_r && (key_r != KEY_END);
  assign is_mod     = (key_r == KEY_SECOND) || (key_r == KEY_ALPHA);
  assign emit       = scan_phase && press_r[0] && !is_mod && (code.cnt != 2'd0);
  assign last_sub   = (sub_r == (code.cnt - 2'd1));
  assign adv        = scan_phase && (!emit || (strm_rdy && last_sub));
  assign take_end   = busy_r && (key_r == KEY_END) && strm_rdy;

  // Pick the byte of an escape sequence or the single character
  always_comb begin
    if (code.arrow && (sub_r == 2'd0)) begin
      byte_val = CHR_ESC;
    end else if (code.arrow && (sub_r == 2'd1)) begin
      byte_val = CHR_BRACKET;
    end else begin
      byte_val = code.chr;
    end
  end

  // Mark chords; toggle the lock on an alpha release with no chord, at the start of row 1
  assign chord_nxt = chord_r | (emit && (lock_r | adown_r));
  assign lock_nxt  = lock_r ^ ((key_r == KEY_ROW0_END) && rel_alpha_r && !chord_nxt);

  assign strm.byte_v   = emit;
  assign strm.byte_val = byte_val;
  assign strm.end_v    = busy_r && (key_r == KEY_END);
  assign scan_stall    = busy_r;

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      key_r   <= 6'd0;
      sub_r   <= 2'd0;
      prev_r  <= '0;
      lock_r  <= 1'b0;
      chord_r <= 1'b0;
      held_r  <= 1'b0;
    end else if (scan_valid && !busy_r) begin
      busy_r <= 1'b1;
      key_r  <= 6'd0;
      sub_r  <= 2'd0;
      prev_r <= scan_bits;
    end else if (adv) begin
      key_r   <= key_r + 6'd1;
      sub_r   <= 2'd0;
      chord_r <= chord_nxt;
      lock_r  <= lock_nxt;
    end else if (emit && strm_rdy) begin
      sub_r <= sub_r + 2'd1;
    end else if (take_end) begin
      busy_r <= 1'b0;
      if (adown_r && !held_r) begin
        chord_r <= 1'b0;
      end
      held_r <= adown_r;
    end
  end

  // Capture the new presses and levels, then shift one key per step
  always_ff @(posedge clk) begin
    if (scan_valid && !busy_r) begin
      press_r     <= scan_bits & ~prev_r;
      rel_alpha_r <= prev_r[KEY_ALPHA] & ~scan_bits[KEY_ALPHA];
      second_r    <= scan_bits[KEY_SECOND];
      adown_r     <= scan_bits[KEY_ALPHA];
    end else if (adv) begin
      press_r <= {1'b0, press_r[KEY_BITS-1:1]};
    end
  end

  `KMAE_ASSERT_IMP(a_key_range, busy_r, key_r <= KEY_END, "key index ran past the end of the scan")
  `KMAE_ASSERT_IMP(a_sub_arrow, sub_r != 2'd0, emit && code.arrow, "byte index set outside an escape sequence")
  `KMAE_ASSERT_NXT(a_end_idle, take_end, !busy_r, "sequencer still busy after end of scan")

endmodule

`default_nettype wire

// ===== hdl/key_matrix_to_ascii_encoder.sv =====
// Key matrix to ASCII encoder.
// Input channel: in_valid / in_stall / in_scan_bits carries one 7x8 key matrix
// scan per transaction (bit row*8+col set while that key is down).
// Output channel: out_valid / out_stall / out_byte / out_last_of_scan carries
// one byte per transaction; out_last_of_scan marks the final byte of a scan.
// A scan that presses no mapped key produces no transaction at all.
// Each scan is walked one key per cycle through a 56-bit shift register,
// except that a key holds while its escape-sequence bytes go out or while
// the byte path is stalled. in_stall is high for the whole walk; the next
// scan is taken the cycle after the end of the previous walk.
// One byte is held back in a pending register so it can be tagged as last;
// a byte is offered the cycle after the sequencer hands over the next byte
// of its scan, or the end of the walk.
// When out_stall is high the output register holds, the pending register
// fills, and the key walk pauses at its next byte or at the end of the scan until the byte path frees up.
// Synchronous reset (rst_n low) clears the previous scan, the alpha lock,
// the chord flags and all valid flags.
`default_nettype none

module key_matrix_to_ascii_encoder (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [55:0] in_scan_bits,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [6:0]       out_byte,
  output logic             out_last_of_scan
);
  import kmae_pkg::*;

  kmae_stream_t strm;
  logic         strm_rdy;
  logic         out_free;
  logic         take_byte;
  logic         take_end;

  logic       pend_v_r;
  logic [6:0] pend_byte_r;
  logic       out_valid_r;
  logic [6:0] out_byte_r;
  logic       out_last_r;

  kmae_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .scan_valid (in_valid),
    .scan_stall (in_stall),
    .scan_bits  (in_scan_bits),
    .strm       (strm),
    .strm_rdy   (strm_rdy)
  );

  // The pending byte can move on when the output register is empty or draining
  assign out_free  = !out_valid_r || !out_stall;
  assign strm_rdy  = !pend_v_r || out_free;
  assign take_byte = strm.byte_v && strm_rdy;
  assign take_end  = strm.end_v && strm_rdy;

  // Output register: push the pending byte, tag it last at end of scan
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pend_v_r && (take_byte || take_end)) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_v_r && (take_byte || take_end)) begin
      out_byte_r <= pend_byte_r;
      out_last_r <= take_end;
    end
  end

  // Pending register: hold the newest byte until its successor or the end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r <= 1'b0;
    end else if (take_byte) begin
      pend_v_r <= 1'b1;
    end else if (take_end) begin
      pend_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take_byte) begin
      pend_byte_r <= strm.byte_val;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_byte         = out_byte_r;
  assign out_last_of_scan = out_last_r;

endmodule

`default_nettype wire
